### hw/rtl/apms_pkg.sv
// Shared types, register codes and constants for the activity power mode selector.
package apms_pkg;

    typedef enum logic [1:0] {
        MODE_SLEEP  = 2'd0,
        MODE_BASIC  = 2'd1,
        MODE_NORMAL = 2'd2,
        MODE_SPORT  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_AUTO_ENABLE         = 3'd0,
        CFG_IDLE_TIMEOUT_BASIC  = 3'd1,
        CFG_IDLE_TIMEOUT_NORMAL = 3'd2,
        CFG_IDLE_TIMEOUT_SPORT  = 3'd3,
        CFG_SPEED_LIMIT         = 3'd4,
        CFG_ACCEL_LIMIT         = 3'd5,
        CFG_YAW_LIMIT           = 3'd6,
        CFG_MIN_DWELL_MS        = 3'd7
    } cfg_index_t;

    localparam logic [31:0] EVAL_PERIOD_MS = 32'd5000;
    localparam logic [31:0] MOTION_HOLD_MS = 32'd10000;

    localparam logic        RST_AUTO_ENABLE         = 1'b1;
    localparam logic [31:0] RST_IDLE_TIMEOUT_BASIC  = 32'd120000;
    localparam logic [31:0] RST_IDLE_TIMEOUT_NORMAL = 32'd300000;
    localparam logic [31:0] RST_IDLE_TIMEOUT_SPORT  = 32'd60000;
    localparam logic [15:0] RST_SPEED_LIMIT         = 16'd300;
    localparam logic [15:0] RST_ACCEL_LIMIT         = 16'd1500;
    localparam logic [15:0] RST_YAW_LIMIT           = 16'd1000;
    localparam logic [31:0] RST_MIN_DWELL_MS        = 32'd30000;

    typedef struct packed {
        logic        auto_enable;
        logic [31:0] idle_timeout_basic;
        logic [31:0] idle_timeout_normal;
        logic [31:0] idle_timeout_sport;
        logic [15:0] speed_limit;
        logic [15:0] accel_limit;
        logic [15:0] yaw_limit;
        logic [31:0] min_dwell_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic               motion_now;
        logic               vehicle_on;
        logic               fix_valid;
        logic [15:0]        speed;
        logic [15:0]        accel_magnitude;
        logic signed [15:0] yaw_rate;
    } item_t;

    typedef struct packed {
        mode_t mode;
        mode_t prior_mode;
        logic  switched;
        logic  moving;
        logic  vehicle_active;
    } result_t;

endpackage

### hw/rtl/apms_cfg_regs.sv
// Configuration register file for the activity power mode selector.
module apms_cfg_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_wdata,
    output apms_pkg::cfg_t       cfg
);

    apms_pkg::cfg_t cfg_reg;
    apms_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (apms_pkg::cfg_index_t'(cfg_index))
                apms_pkg::CFG_AUTO_ENABLE:         cfg_next.auto_enable = cfg_wdata[0];
                apms_pkg::CFG_IDLE_TIMEOUT_BASIC:  cfg_next.idle_timeout_basic = cfg_wdata;
                apms_pkg::CFG_IDLE_TIMEOUT_NORMAL: cfg_next.idle_timeout_normal = cfg_wdata;
                apms_pkg::CFG_IDLE_TIMEOUT_SPORT:  cfg_next.idle_timeout_sport = cfg_wdata;
                apms_pkg::CFG_SPEED_LIMIT:         cfg_next.speed_limit = cfg_wdata[15:0];
                apms_pkg::CFG_ACCEL_LIMIT:         cfg_next.accel_limit = cfg_wdata[15:0];
                apms_pkg::CFG_YAW_LIMIT:           cfg_next.yaw_limit = cfg_wdata[15:0];
                apms_pkg::CFG_MIN_DWELL_MS:        cfg_next.min_dwell_ms = cfg_wdata;
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_enable         <= apms_pkg::RST_AUTO_ENABLE;
            cfg_reg.idle_timeout_basic  <= apms_pkg::RST_IDLE_TIMEOUT_BASIC;
            cfg_reg.idle_timeout_normal <= apms_pkg::RST_IDLE_TIMEOUT_NORMAL;
            cfg_reg.idle_timeout_sport  <= apms_pkg::RST_IDLE_TIMEOUT_SPORT;
            cfg_reg.speed_limit         <= apms_pkg::RST_SPEED_LIMIT;
            cfg_reg.accel_limit         <= apms_pkg::RST_ACCEL_LIMIT;
            cfg_reg.yaw_limit           <= apms_pkg::RST_YAW_LIMIT;
            cfg_reg.min_dwell_ms        <= apms_pkg::RST_MIN_DWELL_MS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/apms_core.sv
// Mode selection state and the combinational update logic for one sample.
module apms_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  apms_pkg::cfg_t       cfg,
    input  apms_pkg::item_t      item,
    input  logic                 fire,
    output apms_pkg::result_t    result
);

    apms_pkg::mode_t mode_reg,       mode_next;
    apms_pkg::mode_t prior_mode_reg, prior_mode_next;
    logic            motion_flag_reg,  motion_flag_next;
    logic            vehicle_flag_reg, vehicle_flag_next;
    logic [31:0]     last_motion_reg,  last_motion_next;
    logic [31:0]     last_change_reg,  last_change_next;
    logic [31:0]     last_eval_reg,    last_eval_next;

    logic [31:0]     motion_elapsed;
    logic [31:0]     idle_elapsed;
    logic [31:0]     eval_elapsed;
    logic [31:0]     change_elapsed;
    logic [31:0]     idle_limit;
    logic            vehicle_rise;
    logic            eval_due;
    logic            fast;
    logic            precise;
    logic [16:0]     yaw_abs;
    apms_pkg::mode_t target;
    logic            switch_now;

    always_comb begin
        motion_elapsed = item.time_ms - last_motion_reg;
        eval_elapsed   = item.time_ms - last_eval_reg;
        change_elapsed = item.time_ms - last_change_reg;
        vehicle_rise   = item.vehicle_on && !vehicle_flag_reg;

        if (item.motion_now) begin
            motion_flag_next = 1'b1;
        end else if (motion_flag_reg && (motion_elapsed > apms_pkg::MOTION_HOLD_MS)) begin
            motion_flag_next = 1'b0;
        end else begin
            motion_flag_next = motion_flag_reg;
        end

        // Both a motion report and an ignition rising edge restart the idle clock.
        last_motion_next  = (item.motion_now || vehicle_rise) ? item.time_ms : last_motion_reg;
        idle_elapsed      = (item.motion_now || vehicle_rise) ? 32'd0 : motion_elapsed;
        vehicle_flag_next = item.vehicle_on;

        case (mode_reg)
            apms_pkg::MODE_BASIC:  idle_limit = cfg.idle_timeout_basic;
            apms_pkg::MODE_NORMAL: idle_limit = cfg.idle_timeout_normal;
            apms_pkg::MODE_SPORT:  idle_limit = cfg.idle_timeout_sport;
            default:               idle_limit = 32'd0;
        endcase

        yaw_abs = item.yaw_rate[15] ? (17'd0 - {item.yaw_rate[15], item.yaw_rate})
                                    : {1'b0, item.yaw_rate};
        fast    = (item.fix_valid && (item.speed > cfg.speed_limit))
               || (item.accel_magnitude > cfg.accel_limit);
        precise = yaw_abs > {1'b0, cfg.yaw_limit};

        if (vehicle_flag_next || motion_flag_next) begin
            target = (fast || precise) ? apms_pkg::MODE_SPORT : apms_pkg::MODE_NORMAL;
        end else if (idle_elapsed > idle_limit) begin
            target = (mode_reg == apms_pkg::MODE_BASIC) ? apms_pkg::MODE_SLEEP
                                                        : apms_pkg::MODE_BASIC;
        end else begin
            target = mode_reg;
        end

        eval_due   = cfg.auto_enable && (eval_elapsed > apms_pkg::EVAL_PERIOD_MS);
        switch_now = eval_due && (target != mode_reg) && (change_elapsed >= cfg.min_dwell_ms);

        last_eval_next   = eval_due ? item.time_ms : last_eval_reg;
        mode_next        = switch_now ? target : mode_reg;
        prior_mode_next  = switch_now ? mode_reg : prior_mode_reg;
        last_change_next = switch_now ? item.time_ms : last_change_reg;

        result.mode           = mode_next;
        result.prior_mode     = prior_mode_next;
        result.switched       = switch_now;
        result.moving         = motion_flag_next;
        result.vehicle_active = vehicle_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= apms_pkg::MODE_NORMAL;
            prior_mode_reg   <= apms_pkg::MODE_NORMAL;
            motion_flag_reg  <= 1'b0;
            vehicle_flag_reg <= 1'b0;
            last_motion_reg  <= 32'd0;
            last_change_reg  <= 32'd0;
            last_eval_reg    <= 32'd0;
        end else if (fire) begin
            mode_reg         <= mode_next;
            prior_mode_reg   <= prior_mode_next;
            motion_flag_reg  <= motion_flag_next;
            vehicle_flag_reg <= vehicle_flag_next;
            last_motion_reg  <= last_motion_next;
            last_change_reg  <= last_change_next;
            last_eval_reg    <= last_eval_next;
        end
    end

endmodule

### hw/rtl/activity_power_mode_selector_top.sv
// Top level of the activity power mode selector: input register, core and result register.
// Each transfer on the s_ channel is one time sample and yields exactly one result transfer
// on the m_ channel. A sample is registered on entry; the mode state is updated from it and
// the result is captured in the output register when the sample leaves the input register,
// which it does once the output register is empty or its result is taken by m_ready. While
// m_ready stays high the block sustains one sample per clock.
// The output register and the input register are decoupled: a new sample is taken while a
// result waits for m_ready, as long as the input register is free. The throughput is set by
// the state update, which closes the loop from one sample to the next. Configuration writes
// take effect on the next clock edge and are meant to be made while no sample is in flight.
module activity_power_mode_selector_top (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_time_ms,
    input  logic               s_motion_now,
    input  logic               s_vehicle_on,
    input  logic               s_fix_valid,
    input  logic [15:0]        s_speed,
    input  logic [15:0]        s_accel_magnitude,
    input  logic signed [15:0] s_yaw_rate,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_mode,
    output logic [1:0]         m_prior_mode,
    output logic               m_switched,
    output logic               m_moving,
    output logic               m_vehicle_active
);

    apms_pkg::cfg_t    cfg;
    apms_pkg::item_t   item_reg;
    apms_pkg::result_t result;
    apms_pkg::result_t res_reg;

    logic in_valid_reg,  in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic fire;

    apms_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    apms_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .fire    (fire),
        .result  (result)
    );

    always_comb begin
        advance        = !out_valid_reg || m_ready;
        fire           = in_valid_reg && advance;
        s_ready        = !in_valid_reg || advance;
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.time_ms         <= s_time_ms;
            item_reg.motion_now      <= s_motion_now;
            item_reg.vehicle_on      <= s_vehicle_on;
            item_reg.fix_valid       <= s_fix_valid;
            item_reg.speed           <= s_speed;
            item_reg.accel_magnitude <= s_accel_magnitude;
            item_reg.yaw_rate        <= s_yaw_rate;
        end
        if (fire) begin
            res_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_mode           = res_reg.mode;
    assign m_prior_mode     = res_reg.prior_mode;
    assign m_switched       = res_reg.switched;
    assign m_moving         = res_reg.moving;
    assign m_vehicle_active = res_reg.vehicle_active;

`ifndef SYNTHESIS
    // A reported mode change always leaves a different mode than it entered.
    a_switch_changes_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_switched) |-> (m_mode != m_prior_mode))
        else $error("switched result with equal mode and prior mode");

    // Mode changes only come from automatic evaluation.
    a_switch_needs_auto: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_switched) |-> cfg.auto_enable)
        else $error("mode changed while automatic evaluation is disabled");

    // A sample that leaves the input register shows up in the result register.
    a_fire_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed sample did not reach the output register");
`endif

endmodule

### tb/apms_mode_checker.sv
// Checker for the activity power mode selector: mode prediction and result comparison.
module apms_mode_checker
    import apms_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [31:0]        s_time_ms,
    input  logic               s_motion_now,
    input  logic               s_vehicle_on,
    input  logic               s_fix_valid,
    input  logic [15:0]        s_speed,
    input  logic [15:0]        s_accel_magnitude,
    input  logic signed [15:0] s_yaw_rate,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_mode,
    input  logic [1:0]         m_prior_mode,
    input  logic               m_switched,
    input  logic               m_moving,
    input  logic               m_vehicle_active,
    output int                 fail_count,
    output int                 outstanding
);

    cfg_t        regs;
    mode_t       mode_now;
    mode_t       mode_before;
    logic        hold_motion;
    logic        veh_seen;
    logic [31:0] t_last_motion;
    logic [31:0] t_last_change;
    logic [31:0] t_last_eval;
    result_t     expected_modes[$];

    task report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    function logic [31:0] idle_limit_of(input mode_t m);
        case (m)
            MODE_BASIC:  return regs.idle_timeout_basic;
            MODE_NORMAL: return regs.idle_timeout_normal;
            MODE_SPORT:  return regs.idle_timeout_sport;
            default:     return 32'd0;
        endcase
    endfunction

    function mode_t choose_target(input item_t smp);
        logic [16:0] yaw_abs;
        logic [31:0] idle_ms;
        logic        fast;
        logic        precise;
        if (veh_seen || hold_motion) begin
            // Magnitude is taken at 17 bits so that the most negative rate stays positive.
            yaw_abs = smp.yaw_rate[15] ? (17'd0 - {1'b1, smp.yaw_rate})
                                       : {1'b0, smp.yaw_rate};
            fast    = (smp.fix_valid && smp.speed > regs.speed_limit) ||
                      (smp.accel_magnitude > regs.accel_limit);
            precise = yaw_abs > {1'b0, regs.yaw_limit};
            if (fast || precise)
                return MODE_SPORT;
            return MODE_NORMAL;
        end
        idle_ms = smp.time_ms - t_last_motion;
        if (idle_ms > idle_limit_of(mode_now)) begin
            if (mode_now == MODE_BASIC)
                return MODE_SLEEP;
            return MODE_BASIC;
        end
        return mode_now;
    endfunction

    task advance_selector(input item_t smp, output result_t res);
        logic [31:0] dt;
        mode_t       target;
        logic        switched;
        switched = 1'b0;
        dt = smp.time_ms - t_last_motion;
        if (smp.motion_now) begin
            hold_motion   = 1'b1;
            t_last_motion = smp.time_ms;
        end else if (hold_motion && dt > MOTION_HOLD_MS) begin
            hold_motion = 1'b0;
        end
        // A rising ignition edge refreshes the idle clock but does not set the held flag.
        if (smp.vehicle_on != veh_seen) begin
            veh_seen = smp.vehicle_on;
            if (smp.vehicle_on)
                t_last_motion = smp.time_ms;
        end
        dt = smp.time_ms - t_last_eval;
        if (regs.auto_enable && dt > EVAL_PERIOD_MS) begin
            t_last_eval = smp.time_ms;
            target = choose_target(smp);
            dt = smp.time_ms - t_last_change;
            if (target != mode_now && dt >= regs.min_dwell_ms) begin
                mode_before   = mode_now;
                mode_now      = target;
                t_last_change = smp.time_ms;
                switched      = 1'b1;
            end
        end
        res.mode           = mode_now;
        res.prior_mode     = mode_before;
        res.switched       = switched;
        res.moving         = hold_motion;
        res.vehicle_active = veh_seen;
    endtask

    always @(posedge aclk) begin
        item_t   smp;
        result_t res;
        result_t want;
        if (!aresetn) begin
            regs.auto_enable         = RST_AUTO_ENABLE;
            regs.idle_timeout_basic  = RST_IDLE_TIMEOUT_BASIC;
            regs.idle_timeout_normal = RST_IDLE_TIMEOUT_NORMAL;
            regs.idle_timeout_sport  = RST_IDLE_TIMEOUT_SPORT;
            regs.speed_limit         = RST_SPEED_LIMIT;
            regs.accel_limit         = RST_ACCEL_LIMIT;
            regs.yaw_limit           = RST_YAW_LIMIT;
            regs.min_dwell_ms        = RST_MIN_DWELL_MS;
            mode_now      = MODE_NORMAL;
            mode_before   = MODE_NORMAL;
            hold_motion   = 1'b0;
            veh_seen      = 1'b0;
            t_last_motion = 32'd0;
            t_last_change = 32'd0;
            t_last_eval   = 32'd0;
            fail_count    = 0;
            expected_modes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_AUTO_ENABLE:         regs.auto_enable         = cfg_wdata[0];
                    CFG_IDLE_TIMEOUT_BASIC:  regs.idle_timeout_basic  = cfg_wdata;
                    CFG_IDLE_TIMEOUT_NORMAL: regs.idle_timeout_normal = cfg_wdata;
                    CFG_IDLE_TIMEOUT_SPORT:  regs.idle_timeout_sport  = cfg_wdata;
                    CFG_SPEED_LIMIT:         regs.speed_limit         = cfg_wdata[15:0];
                    CFG_ACCEL_LIMIT:         regs.accel_limit         = cfg_wdata[15:0];
                    CFG_YAW_LIMIT:           regs.yaw_limit           = cfg_wdata[15:0];
                    CFG_MIN_DWELL_MS:        regs.min_dwell_ms        = cfg_wdata;
                    default: ;
                endcase
            end
            // The result side is checked first, so a stray result never matches a sample
            // that is accepted on the same edge.
            if (m_valid && m_ready) begin
                if (expected_modes.size() == 0) begin
                    report_mismatch("result transfer with no sample outstanding");
                end else begin
                    want = expected_modes.pop_front();
                    if (m_mode !== want.mode)
                        report_mismatch($sformatf("mode: got %0d, expected %0d",
                                                  m_mode, want.mode));
                    if (m_prior_mode !== want.prior_mode)
                        report_mismatch($sformatf("prior_mode: got %0d, expected %0d",
                                                  m_prior_mode, want.prior_mode));
                    if (m_switched !== want.switched)
                        report_mismatch($sformatf("switched: got %b, expected %b",
                                                  m_switched, want.switched));
                    if (m_moving !== want.moving)
                        report_mismatch($sformatf("moving: got %b, expected %b",
                                                  m_moving, want.moving));
                    if (m_vehicle_active !== want.vehicle_active)
                        report_mismatch($sformatf("vehicle_active: got %b, expected %b",
                                                  m_vehicle_active, want.vehicle_active));
                end
            end
            if (s_valid && s_ready) begin
                smp.time_ms         = s_time_ms;
                smp.motion_now      = s_motion_now;
                smp.vehicle_on      = s_vehicle_on;
                smp.fix_valid       = s_fix_valid;
                smp.speed           = s_speed;
                smp.accel_magnitude = s_accel_magnitude;
                smp.yaw_rate        = s_yaw_rate;
                advance_selector(smp, res);
                expected_modes.push_back(res);
            end
        end
        outstanding = expected_modes.size();
    end

endmodule

### tb/tb_activity_power_mode_selector_top.sv
// Testbench top for the activity power mode selector: clock, reset, stimulus and verdict.
module tb_activity_power_mode_selector_top;
    import apms_pkg::*;

    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               cfg_we            = 1'b0;
    logic [2:0]         cfg_index         = 3'd0;
    logic [31:0]        cfg_wdata         = 32'd0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic [31:0]        s_time_ms         = 32'd0;
    logic               s_motion_now      = 1'b0;
    logic               s_vehicle_on      = 1'b0;
    logic               s_fix_valid       = 1'b0;
    logic [15:0]        s_speed           = 16'd0;
    logic [15:0]        s_accel_magnitude = 16'd0;
    logic signed [15:0] s_yaw_rate        = 16'sd0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic [1:0]         m_mode;
    logic [1:0]         m_prior_mode;
    logic               m_switched;
    logic               m_moving;
    logic               m_vehicle_active;

    int          fail_count;
    int          outstanding;
    bit          idle_en     = 1'b1;
    int          stall_left  = 0;
    logic [31:0] now_ms      = 32'd0;
    bit          active      = 1'b0;
    bit          veh_state   = 1'b0;

    always #10 aclk = ~aclk;

    activity_power_mode_selector_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_ms         (s_time_ms),
        .s_motion_now      (s_motion_now),
        .s_vehicle_on      (s_vehicle_on),
        .s_fix_valid       (s_fix_valid),
        .s_speed           (s_speed),
        .s_accel_magnitude (s_accel_magnitude),
        .s_yaw_rate        (s_yaw_rate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mode            (m_mode),
        .m_prior_mode      (m_prior_mode),
        .m_switched        (m_switched),
        .m_moving          (m_moving),
        .m_vehicle_active  (m_vehicle_active)
    );

    apms_mode_checker mode_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_ms         (s_time_ms),
        .s_motion_now      (s_motion_now),
        .s_vehicle_on      (s_vehicle_on),
        .s_fix_valid       (s_fix_valid),
        .s_speed           (s_speed),
        .s_accel_magnitude (s_accel_magnitude),
        .s_yaw_rate        (s_yaw_rate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mode            (m_mode),
        .m_prior_mode      (m_prior_mode),
        .m_switched        (m_switched),
        .m_moving          (m_moving),
        .m_vehicle_active  (m_vehicle_active),
        .fail_count        (fail_count),
        .outstanding       (outstanding)
    );

    // Result back-pressure comes in random bursts, which start only while idle_en is set.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function item_t mk_sample(input logic [31:0] t, input bit mot, input bit veh,
                              input bit fix, input int spd, input int acc, input int yaw);
        item_t smp;
        smp.time_ms         = t;
        smp.motion_now      = mot;
        smp.vehicle_on      = veh;
        smp.fix_valid       = fix;
        smp.speed           = 16'(spd);
        smp.accel_magnitude = 16'(acc);
        smp.yaw_rate        = 16'(yaw);
        return smp;
    endfunction

    // Time mostly advances in steps around the evaluation period, with the odd long
    // silence and the odd jump anywhere in the 32-bit range.
    function item_t next_sample();
        item_t smp;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 15)
            now_ms += $urandom_range(0, 1000);
        else if (r < 75)
            now_ms += $urandom_range(1000, 6000);
        else if (r < 85)
            now_ms += $urandom_range(5000, 5002);
        else if (r < 95)
            now_ms += $urandom_range(10000, 40000);
        else
            now_ms += $urandom;
        if ($urandom_range(0, 9) == 0)
            active = ~active;
        if ($urandom_range(0, 14) == 0)
            veh_state = ~veh_state;
        smp.time_ms    = now_ms;
        smp.motion_now = active ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 29) == 0);
        smp.vehicle_on = veh_state;
        smp.fix_valid  = $urandom_range(0, 4) != 0;
        smp.speed      = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 700));
        smp.accel_magnitude = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 3000));
        smp.yaw_rate   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 3000) - 1500);
        return smp;
    endfunction

    task send_sample(input item_t smp);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_time_ms         <= smp.time_ms;
        s_motion_now      <= smp.motion_now;
        s_vehicle_on      <= smp.vehicle_on;
        s_fix_valid       <= smp.fix_valid;
        s_speed           <= smp.speed;
        s_accel_magnitude <= smp.accel_magnitude;
        s_yaw_rate        <= smp.yaw_rate;
        do @(posedge aclk); while (!s_ready);
    endtask

    task send(input logic [31:0] t, input bit mot, input bit veh, input bit fix,
              input int spd, input int acc, input int yaw);
        send_sample(mk_sample(t, mot, veh, fix, spd, acc, yaw));
    endtask

    task run_random(input int count);
        for (int i = 0; i < count; i++)
            send_sample(next_sample());
    endtask

    // Drops valid and waits until every result has been taken and the pipeline is empty.
    task settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (4) @(negedge aclk);
    endtask

    task write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task program_regs(input logic en, input logic [31:0] basic, input logic [31:0] normal,
                      input logic [31:0] sport, input logic [15:0] spd,
                      input logic [15:0] acc, input logic [15:0] yaw,
                      input logic [31:0] dwell);
        write_reg(CFG_AUTO_ENABLE, {31'd0, en});
        write_reg(CFG_IDLE_TIMEOUT_BASIC, basic);
        write_reg(CFG_IDLE_TIMEOUT_NORMAL, normal);
        write_reg(CFG_IDLE_TIMEOUT_SPORT, sport);
        write_reg(CFG_SPEED_LIMIT, {16'd0, spd});
        write_reg(CFG_ACCEL_LIMIT, {16'd0, acc});
        write_reg(CFG_YAW_LIMIT, {16'd0, yaw});
        write_reg(CFG_MIN_DWELL_MS, dwell);
    endtask

    initial begin
        #4_000_000;
        $display("activity_power_mode_selector_top verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed samples under the reset settings. Thresholds are strict, the motion
        // hold lasts 10 s, an ignition edge restarts the idle clock, and the idle chain
        // runs sport to basic to sleep and back to basic before time wraps.
        send(32'd0, 0, 0, 0, 0, 0, 0);
        send(32'd5000, 0, 0, 0, 0, 0, 0);
        send(32'd5001, 1, 0, 1, 300, 1500, 1000);
        send(32'd10002, 0, 0, 0, 65535, 0, -1000);
        send(32'd15003, 0, 0, 1, 0, 0, 0);
        send(32'd30000, 0, 1, 1, 301, 0, 0);
        send(32'd35001, 0, 1, 0, 65535, 0, 0);
        send(32'd40002, 0, 1, 1, 0, 0, -32768);
        send(32'd60000, 0, 1, 1, 0, 1501, 32767);
        send(32'd65001, 0, 0, 1, 0, 0, 0);
        send(32'd100000, 0, 0, 0, 0, 0, 0);
        send(32'd130000, 0, 0, 0, 0, 0, 0);
        send(32'd160001, 0, 0, 0, 0, 0, 0);
        send(32'd200000, 0, 0, 0, 0, 0, 0);
        send(32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0);
        send(32'hFFFF_FFFF, 1, 1, 1, 65535, 65535, -1);
        send(32'd5120, 0, 1, 0, 0, 0, 0);
        settle();
        // With evaluation off nothing moves; the most negative yaw rate then clears a
        // limit of 32767 while the top speed and acceleration do not.
        write_reg(CFG_YAW_LIMIT, 32'd32767);
        write_reg(CFG_SPEED_LIMIT, 32'd65535);
        write_reg(CFG_ACCEL_LIMIT, 32'd65535);
        write_reg(CFG_MIN_DWELL_MS, 32'd0);
        write_reg(CFG_AUTO_ENABLE, 32'd0);
        send(32'd20000, 1, 0, 1, 65535, 65535, -32768);
        send(32'd26000, 1, 0, 1, 65535, 65535, -32768);
        settle();
        write_reg(CFG_AUTO_ENABLE, 32'd1);
        send(32'd30000, 1, 0, 1, 65535, 65535, -32768);
        send(32'd35001, 1, 0, 1, 65535, 65535, 32767);
        settle();

        now_ms = 32'd40000;
        program_regs(1'b1, 32'd120000, 32'd300000, 32'd60000, 16'd300, 16'd1500,
                     16'd1000, 32'd30000);
        run_random(90);
        settle();

        program_regs(1'b1, 32'd8000, 32'd15000, 32'd6000, 16'd200, 16'd800, 16'd500,
                     32'd10000);
        run_random(100);
        settle();

        program_regs(1'b1, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0);
        run_random(60);
        settle();

        now_ms = 32'hFFFE_0000;
        program_regs(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                     16'hFFFF, 16'h8000, 32'hFFFF_FFFF);
        run_random(60);
        settle();

        idle_en = 1'b0;
        program_regs(1'b1, 32'($urandom_range(0, 60000)), 32'($urandom_range(0, 90000)),
                     32'($urandom_range(0, 40000)), 16'($urandom_range(0, 700)),
                     16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1500)),
                     32'($urandom_range(0, 40000)));
        run_random(90);
        settle();

        idle_en = 1'b1;
        program_regs(1'b0, 32'd8000, 32'd15000, 32'd6000, 16'd250, 16'd1000, 16'd700,
                     32'd5000);
        run_random(40);
        settle();
        write_reg(CFG_AUTO_ENABLE, 32'd1);
        run_random(40);
        settle();

        // The closing stretch runs with both sides always ready.
        idle_en = 1'b0;
        program_regs(1'b1, 32'd10000, 32'd20000, 32'd7000, 16'd300, 16'd1500, 16'd1000,
                     32'd12000);
        run_random(80);
        settle();
        repeat (10) @(posedge aclk);

        if (fail_count == 0)
            $display("activity_power_mode_selector_top verification clean");
        else
            $display("activity_power_mode_selector_top verification failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/apms_pkg.sv
hw/rtl/apms_cfg_regs.sv
hw/rtl/apms_core.sv
hw/rtl/activity_power_mode_selector_top.sv
tb/apms_mode_checker.sv
tb/tb_activity_power_mode_selector_top.sv
